>>> rtl/core/table_driven_timed_sequencer_macros.svh
// Assertion macros used by the sequencer controller.
`ifndef TABLE_DRIVEN_TIMED_SEQUENCER_MACROS_SVH
`define TABLE_DRIVEN_TIMED_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TDTS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sequencer check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TDTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sequencer check failed");

`endif

>>> rtl/core/tdts_pkg.sv
// Shared types, command codes and sizes of the timed sequencer.
`default_nettype none

package tdts_pkg;

	// Default table depth
	localparam int NUM_STATES_DEF = 16;

	// Command codes (6 and 7 do nothing)
	localparam logic [2:0] CMD_TICK  = 3'd0;
	localparam logic [2:0] CMD_WRITE = 3'd1;
	localparam logic [2:0] CMD_START = 3'd2;
	localparam logic [2:0] CMD_FORCE = 3'd3;
	localparam logic [2:0] CMD_ALT   = 3'd4;
	localparam logic [2:0] CMD_DELAY = 3'd5;

	// One table entry as stored in the RAM
	typedef struct packed {
		logic [15:0] steps;
		logic [14:0] delay;
		logic [3:0]  primary;
		logic [3:0]  alternate;
		logic        has_action;
		logic        has_delay_event;
		logic [15:0] tag;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Controller to datapath commands
	typedef struct packed {
		logic rd_en;     // read the table for a load
		logic rd_zero;   // load targets entry 0 (start)
		logic wr_en;     // write a table entry
		logic exec;      // request with no table read, apply now
		logic load;      // table data is valid, load it
		logic load_tick; // the load comes from a tick
	} ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic trans_due; // no steps and no delay left
	} sts_t;

endpackage

`default_nettype wire

>>> rtl/core/tdts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none

module tdts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/tdts_ctrl.sv
// Controller: accepts requests, sequences table loads, strobes results.
`default_nettype none

module tdts_ctrl
	import tdts_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [2:0] command,
	input  wire sts_t       sts,
	output ctl_t            ctl,
	output logic            busy,
	output logic            done
);

`include "table_driven_timed_sequencer_macros.svh"

	typedef enum logic {
		ST_IDLE,
		ST_LOAD
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;
	logic   load_tick_q;
	logic   accept;
	logic   is_load;

	// Request decode
	assign accept  = start && !busy_q;
	assign is_load = (command == CMD_START) || ((command == CMD_TICK) && sts.trans_due);

	// Commands to the datapath
	always_comb begin
		ctl           = '0;
		ctl.rd_en     = accept && is_load;
		ctl.rd_zero   = command == CMD_START;
		ctl.wr_en     = accept && (command == CMD_WRITE);
		ctl.exec      = accept && !is_load;
		ctl.load      = state_q == ST_LOAD;
		ctl.load_tick = load_tick_q;
	end

	// State and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
			load_tick_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					done_q <= accept && !is_load;
					if (accept && is_load) begin
						state_q     <= ST_LOAD;
						busy_q      <= 1'b1;
						load_tick_q <= command == CMD_TICK;
					end
				end
				ST_LOAD: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

	// A load request blocks the next cycle and holds its result back
	`TDTS_ASSERT_NEXT(a_load_blocks, accept && is_load, busy_q && !done_q)
	// The load state is followed by a result with busy low
	`TDTS_ASSERT_NEXT(a_load_done, state_q == ST_LOAD, done_q && !busy_q)
	// A request with no table read gives its result right after acceptance
	`TDTS_ASSERT_NEXT(a_exec_done, accept && !is_load, done_q && !busy_q)

endmodule

`default_nettype wire

>>> rtl/core/tdts_dp.sv
// Datapath: state table, current-entry registers and event outputs.
`default_nettype none

module tdts_dp
	import tdts_pkg::*;
#(
	parameter int NUM_STATES = NUM_STATES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ctl_t               ctl,
	output sts_t                    sts,
	input  wire logic [2:0]         command,
	input  wire logic [3:0]         entry_index,
	input  wire logic [15:0]        entry_steps,
	input  wire logic [14:0]        entry_delay,
	input  wire logic [3:0]         entry_primary_next,
	input  wire logic [3:0]         entry_alternate_next,
	input  wire logic               entry_has_action,
	input  wire logic               entry_has_delay_event,
	input  wire logic [15:0]        entry_cycle_tag,
	input  wire logic signed [15:0] new_delay,
	output logic                    action_fired,
	output logic                    delay_event_fired,
	output logic [3:0]              event_state,
	output logic [3:0]              current_state,
	output logic signed [16:0]      steps_left,
	output logic [14:0]             delay_left,
	output logic [15:0]             current_cycle_tag,
	output logic                    alternate_pending
);

	localparam int AW = $clog2(NUM_STATES);

	// Current entry
	logic [3:0]         cur_index_q;
	logic signed [16:0] cur_steps_q;
	logic [14:0]        cur_delay_q;
	logic [3:0]         cur_prim_q;
	logic [3:0]         cur_alt_q;
	logic               cur_act_q;
	logic               cur_dev_q;
	logic [15:0]        cur_tag_q;
	logic               alt_req_q;
	// Load target and event outputs
	logic [3:0]         load_idx_q;
	logic               act_q;
	logic               dev_q;
	logic [3:0]         ev_state_q;

	logic [3:0]         nxt_raw;
	logic [3:0]         nxt_mod;
	logic [3:0]         rd_idx;
	logic               idx_ok;
	entry_t             wr_entry;
	entry_t             rd_entry;
	logic [ENTRY_W-1:0] rd_data;

	// Next target reduced into the table range
	always_comb begin
		nxt_raw = alt_req_q ? cur_alt_q : cur_prim_q;
		nxt_mod = nxt_raw;
		for (int i = 0; i < 8; i++) begin
			if (32'(nxt_mod) >= NUM_STATES) begin
				nxt_mod = nxt_mod - 4'(NUM_STATES);
			end
		end
	end

	assign rd_idx        = ctl.rd_zero ? 4'd0 : nxt_mod;
	assign idx_ok        = 32'(entry_index) < NUM_STATES;
	assign sts.trans_due = (cur_steps_q[16] || (cur_steps_q == '0)) && (cur_delay_q == '0);

	// Entry to store
	always_comb begin
		wr_entry.steps           = entry_steps;
		wr_entry.delay           = entry_delay;
		wr_entry.primary         = entry_primary_next;
		wr_entry.alternate       = entry_alternate_next;
		wr_entry.has_action      = entry_has_action;
		wr_entry.has_delay_event = entry_has_delay_event;
		wr_entry.tag             = entry_cycle_tag;
	end

	tdts_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NUM_STATES)
	) u_table (
		.clk  (clk),
		.we   (ctl.wr_en && idx_ok),
		.waddr(AW'(entry_index)),
		.wdata(wr_entry),
		.re   (ctl.rd_en),
		.raddr(AW'(rd_idx)),
		.rdata(rd_data)
	);

	assign rd_entry = entry_t'(rd_data);

	// Current entry update and event capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_index_q <= '0;
			cur_steps_q <= '0;
			cur_delay_q <= '0;
			cur_prim_q  <= '0;
			cur_alt_q   <= '0;
			cur_act_q   <= 1'b0;
			cur_dev_q   <= 1'b0;
			cur_tag_q   <= '0;
			alt_req_q   <= 1'b0;
			load_idx_q  <= '0;
			act_q       <= 1'b0;
			dev_q       <= 1'b0;
			ev_state_q  <= '0;
		end else begin
			if (ctl.rd_en) begin
				load_idx_q <= rd_idx;
			end
			if (ctl.exec) begin
				act_q      <= 1'b0;
				dev_q      <= 1'b0;
				ev_state_q <= cur_index_q;
				case (command)
					CMD_TICK: begin
						if (!cur_steps_q[16] && (cur_steps_q != '0)) begin
							act_q       <= cur_act_q;
							cur_steps_q <= cur_steps_q - 17'sd1;
						end else begin
							// delay is known to be nonzero here
							cur_delay_q <= cur_delay_q - 15'd1;
							if ((cur_delay_q == 15'd1) && cur_dev_q) begin
								dev_q     <= 1'b1;
								cur_dev_q <= 1'b0;
							end
						end
					end
					CMD_FORCE: begin
						cur_steps_q <= '0;
					end
					CMD_ALT: begin
						alt_req_q <= 1'b1;
					end
					CMD_DELAY: begin
						if (!new_delay[15] && (new_delay != '0)) begin
							cur_delay_q <= new_delay[14:0];
						end
					end
					default: begin
					end
				endcase
			end
			if (ctl.load) begin
				cur_index_q <= load_idx_q;
				cur_delay_q <= rd_entry.delay;
				cur_prim_q  <= rd_entry.primary;
				cur_alt_q   <= rd_entry.alternate;
				cur_act_q   <= rd_entry.has_action;
				cur_dev_q   <= rd_entry.has_delay_event;
				cur_tag_q   <= rd_entry.tag;
				alt_req_q   <= 1'b0;
				if (ctl.load_tick) begin
					// old delay event and new action may both fire
					cur_steps_q <= $signed({1'b0, rd_entry.steps}) - 17'sd1;
					act_q       <= rd_entry.has_action;
					dev_q       <= cur_dev_q;
					ev_state_q  <= (rd_entry.has_action || !cur_dev_q) ? load_idx_q
						: cur_index_q;
				end else begin
					cur_steps_q <= $signed({1'b0, rd_entry.steps});
					act_q       <= 1'b0;
					dev_q       <= 1'b0;
					ev_state_q  <= load_idx_q;
				end
			end
		end
	end

	assign action_fired      = act_q;
	assign delay_event_fired = dev_q;
	assign event_state       = ev_state_q;
	assign current_state     = cur_index_q;
	assign steps_left        = cur_steps_q;
	assign delay_left        = cur_delay_q;
	assign current_cycle_tag = cur_tag_q;
	assign alternate_pending = alt_req_q;

endmodule

`default_nettype wire

>>> rtl/core/table_driven_timed_sequencer.sv
// Top level of the table-driven timed sequencer.
//
// Requests enter on start with command and the entry/delay fields; a request
// is taken at a clock edge where start is high and busy is low. Every request
// gives exactly one result, shown for one cycle with done high; the receiver
// cannot stall, so results must be taken as they appear.
// Write, force, alternate, set-delay and ticks that only count steps or
// delay give done in the cycle after acceptance and keep busy low, so such
// requests may follow every cycle. A start, or a tick that moves to the
// next state, reads the state table: busy is high for one cycle and done
// rises as busy falls again. The single read port of the table RAM, with
// its registered read, is why such a request passes through a load state.
// Reset clears the current state (index 0, zero steps, delay and tag) and the
// alternate request; table contents are undefined until written, so entries
// must be written before start or a transition reaches them.
`default_nettype none

module table_driven_timed_sequencer
	import tdts_pkg::*;
#(
	parameter int NUM_STATES = NUM_STATES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         command,
	input  wire logic [3:0]         entry_index,
	input  wire logic [15:0]        entry_steps,
	input  wire logic [14:0]        entry_delay,
	input  wire logic [3:0]         entry_primary_next,
	input  wire logic [3:0]         entry_alternate_next,
	input  wire logic               entry_has_action,
	input  wire logic               entry_has_delay_event,
	input  wire logic [15:0]        entry_cycle_tag,
	input  wire logic signed [15:0] new_delay,
	output logic                    done,
	output logic                    action_fired,
	output logic                    delay_event_fired,
	output logic [3:0]              event_state,
	output logic [3:0]              current_state,
	output logic signed [16:0]      steps_left,
	output logic [14:0]             delay_left,
	output logic [15:0]             current_cycle_tag,
	output logic                    alternate_pending
);

	ctl_t ctl;
	sts_t sts;

	tdts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.command(command),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	tdts_dp #(
		.NUM_STATES(NUM_STATES)
	) u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.ctl                  (ctl),
		.sts                  (sts),
		.command              (command),
		.entry_index          (entry_index),
		.entry_steps          (entry_steps),
		.entry_delay          (entry_delay),
		.entry_primary_next   (entry_primary_next),
		.entry_alternate_next (entry_alternate_next),
		.entry_has_action     (entry_has_action),
		.entry_has_delay_event(entry_has_delay_event),
		.entry_cycle_tag      (entry_cycle_tag),
		.new_delay            (new_delay),
		.action_fired         (action_fired),
		.delay_event_fired    (delay_event_fired),
		.event_state          (event_state),
		.current_state        (current_state),
		.steps_left           (steps_left),
		.delay_left           (delay_left),
		.current_cycle_tag    (current_cycle_tag),
		.alternate_pending    (alternate_pending)
	);

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for the table-driven timed sequencer.
`timescale 1ns / 1ps

module tb_top;
	import tdts_pkg::*;

	// Unused command codes, accepted and ignored by the block
	localparam logic [2:0] CMD_NOP6 = 3'd6;
	localparam logic [2:0] CMD_NOP7 = 3'd7;
	localparam int DIR_N = 25;
	localparam int RAND_N = 825;

	typedef struct packed {
		logic [2:0]         cmd;
		logic [3:0]         idx;
		logic [15:0]        steps;
		logic [14:0]        delay;
		logic [3:0]         prim;
		logic [3:0]         alt;
		logic               act;
		logic               dev;
		logic [15:0]        tag;
		logic signed [15:0] ndelay;
	} seq_req_t;

	typedef struct packed {
		logic               act;
		logic               dev;
		logic [3:0]         ev_state;
		logic [3:0]         cur_state;
		logic signed [16:0] steps;
		logic [14:0]        delay;
		logic [15:0]        tag;
		logic               alt;
	} seq_result_t;

	typedef struct packed {
		seq_req_t    req;
		logic        typed;
		seq_result_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [2:0] command = CMD_TICK;
	logic [3:0] entry_index = '0;
	logic [15:0] entry_steps = '0;
	logic [14:0] entry_delay = '0;
	logic [3:0] entry_primary_next = '0;
	logic [3:0] entry_alternate_next = '0;
	logic entry_has_action = 1'b0;
	logic entry_has_delay_event = 1'b0;
	logic [15:0] entry_cycle_tag = '0;
	logic signed [15:0] new_delay = '0;
	logic busy;
	logic done;
	logic action_fired;
	logic delay_event_fired;
	logic [3:0] event_state;
	logic [3:0] current_state;
	logic signed [16:0] steps_left;
	logic [14:0] delay_left;
	logic [15:0] current_cycle_tag;
	logic alternate_pending;

	// Sequencer state mirrored by the predictor
	entry_t             seq_tbl [16];
	logic [15:0]        seq_written = '0;
	logic [3:0]         cur_idx = '0;
	logic signed [16:0] cur_steps = '0;
	logic [14:0]        cur_delay = '0;
	entry_t             cur_ent = '0;
	logic               alt_req = 1'b0;

	seq_result_t awaited_outputs [$];
	seq_result_t got;
	seq_result_t want;
	int unsigned mismatches = 0;
	bit idle_on = 1'b1;
	dir_row_t dir_tbl [DIR_N];

	table_driven_timed_sequencer u_dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.start                (start),
		.busy                 (busy),
		.command              (command),
		.entry_index          (entry_index),
		.entry_steps          (entry_steps),
		.entry_delay          (entry_delay),
		.entry_primary_next   (entry_primary_next),
		.entry_alternate_next (entry_alternate_next),
		.entry_has_action     (entry_has_action),
		.entry_has_delay_event(entry_has_delay_event),
		.entry_cycle_tag      (entry_cycle_tag),
		.new_delay            (new_delay),
		.done                 (done),
		.action_fired         (action_fired),
		.delay_event_fired    (delay_event_fired),
		.event_state          (event_state),
		.current_state        (current_state),
		.steps_left           (steps_left),
		.delay_left           (delay_left),
		.current_cycle_tag    (current_cycle_tag),
		.alternate_pending    (alternate_pending)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Make an entry current; clears any alternate request
	function automatic void load_entry(input logic [3:0] idx);
		cur_idx = idx;
		cur_ent = seq_tbl[idx];
		cur_steps = {1'b0, cur_ent.steps};
		cur_delay = cur_ent.delay;
		alt_req = 1'b0;
	endfunction

	// Advance the mirrored sequencer by one request and return its outputs
	function automatic seq_result_t step_sequencer(input seq_req_t rq);
		seq_result_t res;
		logic [3:0] old_idx;
		logic [3:0] nxt;
		res = '0;
		old_idx = cur_idx;
		case (rq.cmd)
			CMD_TICK: begin
				if (cur_steps > 0) begin
					res.act = cur_ent.has_action;
					cur_steps = cur_steps - 17'sd1;
				end else if (cur_delay != 0) begin
					cur_delay = cur_delay - 15'd1;
					if (cur_delay == 0 && cur_ent.has_delay_event) begin
						res.dev = 1'b1;
						cur_ent.has_delay_event = 1'b0;
					end
				end else begin
					// transition: old delay event, then new entry's action
					nxt = alt_req ? cur_ent.alternate : cur_ent.primary;
					res.dev = cur_ent.has_delay_event;
					load_entry(nxt);
					res.act = cur_ent.has_action;
					cur_steps = cur_steps - 17'sd1;
				end
			end
			CMD_WRITE: begin
				seq_tbl[rq.idx] = '{steps: rq.steps, delay: rq.delay, primary: rq.prim,
					alternate: rq.alt, has_action: rq.act, has_delay_event: rq.dev,
					tag: rq.tag};
				seq_written[rq.idx] = 1'b1;
			end
			CMD_START: load_entry(4'd0);
			CMD_FORCE: cur_steps = '0;
			CMD_ALT: alt_req = 1'b1;
			CMD_DELAY: begin
				if (rq.ndelay > 0)
					cur_delay = rq.ndelay[14:0];
			end
			default: ;
		endcase
		res.ev_state = (res.act || !res.dev) ? cur_idx : old_idx;
		res.cur_state = cur_idx;
		res.steps = cur_steps;
		res.delay = cur_delay;
		res.tag = cur_ent.tag;
		res.alt = alt_req;
		return res;
	endfunction

	// Directed row for a non-write command; typed rows carry their own answer
	function automatic dir_row_t op_row(input logic [2:0] cmd, input logic signed [15:0] nd,
		input logic typed, input logic [14:0] d_exp, input logic a_exp);
		dir_row_t row;
		row = '0;
		row.req.cmd = cmd;
		row.req.ndelay = nd;
		row.typed = typed;
		row.want.delay = d_exp;
		row.want.alt = a_exp;
		return row;
	endfunction

	function automatic dir_row_t wr_row(input logic [3:0] idx, input logic [15:0] steps,
		input logic [14:0] delay, input logic [3:0] prim, input logic [3:0] alt,
		input logic act, input logic dev, input logic [15:0] tag);
		dir_row_t row;
		row = '0;
		row.req = '{cmd: CMD_WRITE, idx: idx, steps: steps, delay: delay, prim: prim,
			alt: alt, act: act, dev: dev, tag: tag, ndelay: '0};
		return row;
	endfunction

	// Next-state target that never leads to an unwritten entry
	function automatic logic [3:0] pick_target(input logic [3:0] idx);
		logic [3:0] t;
		do
			t = 4'($urandom_range(15));
		while (!(seq_written[t] || t == idx));
		return t;
	endfunction

	// Mostly ticks and well-formed table writes, small counts with rare extremes
	function automatic seq_req_t rand_request();
		seq_req_t rq;
		int unsigned pick;
		rq.idx = 4'($urandom_range(15));
		rq.steps = 16'($urandom_range(65535));
		rq.delay = 15'($urandom_range(32767));
		rq.prim = 4'($urandom_range(15));
		rq.alt = 4'($urandom_range(15));
		rq.act = 1'($urandom_range(1));
		rq.dev = 1'($urandom_range(1));
		rq.tag = 16'($urandom_range(65535));
		rq.ndelay = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
			: 16'($urandom_range(1, 4));
		pick = $urandom_range(99);
		if (pick < 52)
			rq.cmd = CMD_TICK;
		else if (pick < 64) begin
			rq.cmd = CMD_WRITE;
			if ($urandom_range(15) != 0)
				rq.steps = 16'($urandom_range(3));
			if ($urandom_range(15) != 0)
				rq.delay = 15'($urandom_range(3));
			rq.prim = pick_target(rq.idx);
			rq.alt = pick_target(rq.idx);
		end else if (pick < 69)
			rq.cmd = CMD_START;
		else if (pick < 77)
			rq.cmd = CMD_FORCE;
		else if (pick < 85)
			rq.cmd = CMD_ALT;
		else if (pick < 96)
			rq.cmd = CMD_DELAY;
		else
			rq.cmd = pick[0] ? CMD_NOP7 : CMD_NOP6;
		return rq;
	endfunction

	// Present one request, wait until taken, then queue its expected outputs
	task automatic issue(input seq_req_t rq, input logic typed, input seq_result_t exp_res);
		seq_result_t pred;
		if (idle_on && $urandom_range(99) < 16) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		start <= 1'b1;
		command <= rq.cmd;
		entry_index <= rq.idx;
		entry_steps <= rq.steps;
		entry_delay <= rq.delay;
		entry_primary_next <= rq.prim;
		entry_alternate_next <= rq.alt;
		entry_has_action <= rq.act;
		entry_has_delay_event <= rq.dev;
		entry_cycle_tag <= rq.tag;
		new_delay <= rq.ndelay;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pred = step_sequencer(rq);
		awaited_outputs.push_back(typed ? exp_res : pred);
	endtask

	task automatic check_field(input string name, input logic [16:0] exp_v,
		input logic [16:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// Result checker: every done pulse is matched against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			got = '{act: action_fired, dev: delay_event_fired, ev_state: event_state,
				cur_state: current_state, steps: steps_left, delay: delay_left,
				tag: current_cycle_tag, alt: alternate_pending};
			if (awaited_outputs.size() == 0) begin
				$display("%0t: result with no request outstanding, expected none, actual %0h",
					$time, got);
				mismatches++;
			end else begin
				want = awaited_outputs.pop_front();
				check_field("action_fired", 17'(want.act), 17'(got.act));
				check_field("delay_event_fired", 17'(want.dev), 17'(got.dev));
				check_field("event_state", 17'(want.ev_state), 17'(got.ev_state));
				check_field("current_state", 17'(want.cur_state), 17'(got.cur_state));
				check_field("steps_left", want.steps, got.steps);
				check_field("delay_left", 17'(want.delay), 17'(got.delay));
				check_field("current_cycle_tag", 17'(want.tag), 17'(got.tag));
				check_field("alternate_pending", 17'(want.alt), 17'(got.alt));
			end
		end
	end

	// Stimulus: directed table, then random requests, then drain
	initial begin
		int n;
		seq_req_t rq;
		dir_tbl = '{
			// idle state after reset: only delay and alternate move
			op_row(CMD_FORCE, 16'sd0, 1'b1, 15'd0, 1'b0),
			op_row(CMD_DELAY, -16'sd32768, 1'b1, 15'd0, 1'b0),
			op_row(CMD_DELAY, 16'sd0, 1'b1, 15'd0, 1'b0),
			op_row(CMD_NOP6, 16'sd0, 1'b1, 15'd0, 1'b0),
			op_row(CMD_NOP7, 16'sd0, 1'b1, 15'd0, 1'b0),
			op_row(CMD_ALT, 16'sd0, 1'b1, 15'd0, 1'b1),
			op_row(CMD_DELAY, 16'sd32767, 1'b1, 15'd32767, 1'b1),
			op_row(CMD_DELAY, 16'sd1, 1'b1, 15'd1, 1'b1),
			// table: one all-ones entry, then a small loop 0 -> 2 -> 0 / 1
			wr_row(4'd15, 16'hFFFF, 15'h7FFF, 4'd0, 4'd0, 1'b1, 1'b1, 16'hFFFF),
			wr_row(4'd1, 16'd1, 15'd2, 4'd0, 4'd15, 1'b1, 1'b1, 16'h1234),
			wr_row(4'd2, 16'd0, 15'd0, 4'd0, 4'd1, 1'b1, 1'b1, 16'h0002),
			wr_row(4'd0, 16'd0, 15'd0, 4'd2, 4'd15, 1'b0, 1'b0, 16'h0000),
			// delay countdown, then zero-step entries down to -1
			op_row(CMD_TICK, 16'sd0, 1'b0, 15'd0, 1'b0),
			op_row(CMD_TICK, 16'sd0, 1'b0, 15'd0, 1'b0),
			op_row(CMD_TICK, 16'sd0, 1'b0, 15'd0, 1'b0),
			// delay event alone at a transition
			op_row(CMD_TICK, 16'sd0, 1'b0, 15'd0, 1'b0),
			op_row(CMD_TICK, 16'sd0, 1'b0, 15'd0, 1'b0),
			// alternate target with both events on one tick
			op_row(CMD_ALT, 16'sd0, 1'b0, 15'd0, 1'b0),
			op_row(CMD_TICK, 16'sd0, 1'b0, 15'd0, 1'b0),
			op_row(CMD_TICK, 16'sd0, 1'b0, 15'd0, 1'b0),
			op_row(CMD_TICK, 16'sd0, 1'b0, 15'd0, 1'b0),
			// new delay after the event fired must not re-arm it
			op_row(CMD_DELAY, 16'sd2, 1'b0, 15'd0, 1'b0),
			op_row(CMD_TICK, 16'sd0, 1'b0, 15'd0, 1'b0),
			op_row(CMD_TICK, 16'sd0, 1'b0, 15'd0, 1'b0),
			op_row(CMD_START, 16'sd0, 1'b0, 15'd0, 1'b0)
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (n = 0; n < DIR_N; n++)
			issue(dir_tbl[n].req, dir_tbl[n].typed, dir_tbl[n].want);
		n = 0;
		while (n < RAND_N) begin
			// back-to-back stretch with no idle gaps
			idle_on = !(n >= 350 && n < 500);
			rq = rand_request();
			issue(rq, 1'b0, '0);
			if (rq.cmd != CMD_NOP6 && rq.cmd != CMD_NOP7)
				n++;
		end
		start <= 1'b0;
		while (awaited_outputs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> table_driven_timed_sequencer.f
+incdir+rtl/core
rtl/core/tdts_pkg.sv
rtl/core/tdts_ram.sv
rtl/core/tdts_ctrl.sv
rtl/core/tdts_dp.sv
rtl/core/table_driven_timed_sequencer.sv
sim/tb_top.sv
